/* src/wsdf_pkg.sv */
// shared types and constants for the websocket frame deframer
// no dependencies; imported by the top level, the parser and the result register
package wsdf_pkg;

    localparam int LEN_BITS_DEFAULT = 64;

    localparam logic [3:0] OPC_CONT = 4'h0;
    localparam logic [3:0] OPC_TEXT = 4'h1;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [2:0] EXT_CNT16 = 3'd1;
    localparam logic [2:0] EXT_CNT64 = 3'd7;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_UNSUP    = 2'd1,
        ST_UNMASKED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       is_continuation;
        t_status    result_status;
    } t_result;

endpackage

/* src/websocket_frame_deframer.sv */
// websocket frame deframer: parses received bytes and unmasks text payload
// input channel: i_rx_valid / o_rx_ready with i_rx_byte, one byte per request
// output channel: o_res_valid / i_res_ready with payload, last, continuation
//   and status fields; a payload byte or a status request per result
// each byte is registered in the input register, then stepped through the
//   parser into the result register, which drives the output channel
// throughput is one byte per cycle while results are taken; the parser steps
//   once per byte (64-bit length decrement and compare is the longest path)
// header bytes, key bytes and dropped payload give no result; a dropped or
//   empty frame gives one status result at the end of its header
// when the receiver stalls, the result register holds and the input register
//   takes one more byte, then o_rx_ready falls until the result is taken
// synchronous active-low reset empties both registers and returns the parser
//   to waiting for the first header byte of a frame
// depends on wsdf_pkg, wsdf_in_reg, wsdf_parser, wsdf_out_reg
module websocket_frame_deframer #(
    parameter int LEN_BITS = wsdf_pkg::LEN_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_last_of_frame,
    output logic       o_is_continuation,
    output logic [1:0] o_result_status
);
    import wsdf_pkg::*;

    logic       adv;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       step;
    logic       par_valid;
    t_result    par_res;
    t_result    out_res;

    assign step = in_valid && adv;

    wsdf_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_adv      (adv),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    wsdf_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (par_valid),
        .o_res       (par_res)
    );

    wsdf_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (par_valid),
        .i_res       (par_res),
        .o_adv       (adv),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (out_res)
    );

    assign o_payload_byte    = out_res.payload_byte;
    assign o_last_of_frame   = out_res.last_of_frame;
    assign o_is_continuation = out_res.is_continuation;
    assign o_result_status   = out_res.result_status;
endmodule

/* src/wsdf_in_reg.sv */
// input register of the deframer: holds one received byte for the parser
// no package dependencies; instanced by the top level
module wsdf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_adv,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    // slot frees when empty or when the parser consumes it this cycle
    assign o_rx_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

/* src/wsdf_parser.sv */
// header parser and unmasking logic: frame state plus one byte step
// depends on wsdf_pkg for phase, status and result types
module wsdf_parser #(
    parameter int LEN_BITS = wsdf_pkg::LEN_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output wsdf_pkg::t_result o_res
);
    import wsdf_pkg::*;

    t_phase              r_phase,     n_phase;
    logic [3:0]          r_opcode,    n_opcode;
    t_status             r_drop,      n_drop;
    logic [2:0]          r_ext_cnt,   n_ext_cnt;
    logic [LEN_BITS-1:0] r_rem,       n_rem;
    logic [3:0][7:0]     r_key,       n_key;
    logic [1:0]          r_key_idx,   n_key_idx;
    logic                r_masked,    n_masked;

    logic                hdr_done;
    logic [LEN_BITS-1:0] len_now;
    logic                masked_in;
    logic [6:0]          len7;

    assign masked_in = i_byte[7];
    assign len7      = i_byte[6:0];

    always_comb begin
        n_phase   = r_phase;
        n_opcode  = r_opcode;
        n_drop    = r_drop;
        n_ext_cnt = r_ext_cnt;
        n_rem     = r_rem;
        n_key     = r_key;
        n_key_idx = r_key_idx;
        n_masked  = r_masked;
        hdr_done  = 1'b0;
        len_now   = r_rem;

        o_res_valid           = 1'b0;
        o_res.payload_byte    = 8'h00;
        o_res.last_of_frame   = 1'b1;
        o_res.is_continuation = (r_opcode == OPC_CONT);
        o_res.result_status   = ST_PAYLOAD;

        case (r_phase)
            PH_HDR1: begin
                if (r_opcode != OPC_CONT && r_opcode != OPC_TEXT) begin
                    n_drop = ST_UNSUP;
                end else if (!masked_in) begin
                    n_drop = ST_UNMASKED;
                end else begin
                    n_drop = ST_PAYLOAD;
                end
                n_rem = '0;
                if (len7 == LEN_EXT16) begin
                    n_ext_cnt = EXT_CNT16;
                    n_phase   = PH_EXT;
                    n_masked  = masked_in;
                end else if (len7 == LEN_EXT64) begin
                    n_ext_cnt = EXT_CNT64;
                    n_phase   = PH_EXT;
                    n_masked  = masked_in;
                end else begin
                    n_rem = {{(LEN_BITS-7){1'b0}}, len7};
                    if (masked_in) begin
                        n_phase   = PH_KEY;
                        n_key_idx = 2'd0;
                    end else begin
                        hdr_done = 1'b1;
                        len_now  = n_rem;
                    end
                end
            end
            PH_EXT: begin
                // a length too wide for the counter saturates
                if (r_rem[LEN_BITS-1 -: 8] != 8'h00) begin
                    n_rem = '1;
                end else begin
                    n_rem = {r_rem[LEN_BITS-9:0], i_byte};
                end
                if (r_ext_cnt != 3'd0) begin
                    n_ext_cnt = r_ext_cnt - 3'd1;
                end else if (r_masked) begin
                    n_phase   = PH_KEY;
                    n_key_idx = 2'd0;
                end else begin
                    hdr_done = 1'b1;
                    len_now  = n_rem;
                end
            end
            PH_KEY: begin
                // key byte 0 lands in the top byte
                n_key[~r_key_idx] = i_byte;
                n_key_idx         = r_key_idx + 2'd1;
                if (r_key_idx == 2'd3) begin
                    hdr_done = 1'b1;
                    len_now  = r_rem;
                end
            end
            PH_DATA: begin
                n_rem = r_rem - {{(LEN_BITS-1){1'b0}}, 1'b1};
                if (n_rem == '0) begin
                    n_phase = PH_HDR0;
                end
                if (r_drop == ST_PAYLOAD) begin
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = i_byte ^ r_key[~r_key_idx];
                    o_res.last_of_frame = (n_rem == '0);
                    n_key_idx           = r_key_idx + 2'd1;
                end
            end
            default: begin
                n_opcode  = i_byte[3:0];
                n_drop    = ST_PAYLOAD;
                n_ext_cnt = 3'd0;
                n_key_idx = 2'd0;
                n_phase   = PH_HDR1;
            end
        endcase

        // end of header: status request for dropped or empty frames
        if (hdr_done) begin
            n_key_idx = 2'd0;
            if (n_drop != ST_PAYLOAD) begin
                o_res_valid         = 1'b1;
                o_res.result_status = n_drop;
            end else if (len_now == '0) begin
                o_res_valid         = 1'b1;
                o_res.result_status = ST_EMPTY;
            end
            n_phase = (len_now == '0) ? PH_HDR0 : PH_DATA;
        end

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_opcode  <= 4'h0;
            r_drop    <= ST_PAYLOAD;
            r_ext_cnt <= 3'd0;
            r_rem     <= '0;
            r_key     <= '0;
            r_key_idx <= 2'd0;
            r_masked  <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_drop    <= n_drop;
            r_ext_cnt <= n_ext_cnt;
            r_rem     <= n_rem;
            r_key     <= n_key;
            r_key_idx <= n_key_idx;
            r_masked  <= n_masked;
        end
    end
endmodule

/* src/wsdf_out_reg.sv */
// result register of the deframer: holds one result until the receiver takes it
// depends on wsdf_pkg for the result struct
module wsdf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  wsdf_pkg::t_result i_res,
    output logic              o_adv,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output wsdf_pkg::t_result o_res
);
    import wsdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    // pipeline moves when the result slot is empty or being drained
    assign o_adv = !r_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;
endmodule
